>>> rtl/core/grm_pkg.sv
// ============================================================================
// grm_pkg
// Shared types and constants for the grid rectangle merge core.
// ============================================================================
package grm_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int LABEL_W         = 12;
    localparam int CFG_W           = 7;
    localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MERGE = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        KIND_LABEL = 1'b0,
        KIND_MERGE = 1'b1
    } kind_t;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ANC_RD,
        ST_ANC_EV,
        ST_RR_RD,
        ST_RR_EV,
        ST_RD_RD,
        ST_RD_EV,
        ST_FC_RD,
        ST_FC_EV,
        ST_FM,
        ST_FIN_RD,
        ST_FIN_EV,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/grm_ram.sv
// ============================================================================
// grm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module grm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/grid_rectangle_merge_core.sv
// ============================================================================
// grid_rectangle_merge_core
// Loads a walk-bit grid, merges it into rectangles, answers label queries.
// ============================================================================
//  channel  | ports            | beat
//  ---------+------------------+------------------------------------------
//  input    | s_valid/s_ready  | operation, cell_index, walkable
//  result   | m_valid/m_ready  | reply_kind, block_label
//  config   | APB psel/penable | grid_width @0x0, grid_height @0x4
//
//  Load and query beats: one per cycle while idle and no query reply waits
//  on m_ready; a query reads the label RAM, then registers its reply. Merge:
//  clear and final label passes over W*H cells around a scan of cell probes.
//  Input stalls for the whole merge. Reset is synchronous, active low.
// ============================================================================
module grid_rectangle_merge_core #(
    parameter int MAX_COLUMNS = grm_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = grm_pkg::MAX_ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [11:0] s_cell_index,
    input  logic        s_walkable,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reply_kind,
    output logic [11:0] m_block_label,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int DW    = (CW > RW) ? CW : RW;
    localparam int PW    = 2 * DW + 1;
    localparam int LW    = grm_pkg::LABEL_W;

    grm_pkg::state_t state_reg, state_next;

    logic [grm_pkg::CFG_W-1:0] gw_reg, gh_reg;
    logic [CW-1:0] ewid_reg, ewid_next, ewid_c;
    logic [RW-1:0] ehgt_reg, ehgt_next, ehgt_c;
    logic [AW:0]   area_reg, area_next, area_c;
    logic          merged_reg, merged_next;
    logic [CW-1:0] c_reg, c_next, pc_reg, pc_next, w_reg, w_next;
    logic [RW-1:0] r_reg, r_next, pr_reg, pr_next, h_reg, h_next;
    logic [DW-1:0] i_reg, i_next, j_reg, j_next;
    logic          b_reg, b_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          q_pend_reg, q_pend_next, q_hit_reg, q_hit_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_kind_reg, m_kind_next;
    logic [LW-1:0] m_label_reg, m_label_next;

    logic          walk_we, walk_re, walk_rdata;
    logic [AW-1:0] walk_waddr, walk_raddr;
    logic          lab_we, lab_re;
    logic [AW-1:0] lab_waddr, lab_raddr;
    logic [LW:0]   lab_wdata, lab_rdata;

    logic          s_acc, out_free, cell_ok, open_c, rowmode, adv, runs_done;
    logic [DW-1:0] ax, ay, n_len, l_len;
    logic [PW-1:0] addr_full;
    logic [AW-1:0] cell_addr;

    grm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_walk_ram (
        .aclk  (aclk),
        .we    (walk_we),
        .waddr (walk_waddr),
        .wdata (s_walkable),
        .re    (walk_re),
        .raddr (walk_raddr),
        .rdata (walk_rdata)
    );

    grm_ram #(.WIDTH(LW + 1), .DEPTH(CELLS)) u_lab_ram (
        .aclk  (aclk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (lab_wdata),
        .re    (lab_re),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    // config port
    assign pready = 1'b1;

    always_comb begin
        case (grm_pkg::reg_idx_t'(paddr[2]))
            grm_pkg::REG_GRID_WIDTH:  prdata = {25'd0, gw_reg};
            grm_pkg::REG_GRID_HEIGHT: prdata = {25'd0, gh_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= grm_pkg::GRID_DIM_RESET;
            gh_reg <= grm_pkg::GRID_DIM_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (grm_pkg::reg_idx_t'(paddr[2]) == grm_pkg::REG_GRID_WIDTH) begin
                gw_reg <= pwdata[grm_pkg::CFG_W-1:0];
            end else begin
                gh_reg <= pwdata[grm_pkg::CFG_W-1:0];
            end
        end
    end

    // effective grid size
    always_comb begin
        if (32'(gw_reg) > 32'(MAX_COLUMNS)) begin
            ewid_c = CW'(MAX_COLUMNS);
        end else begin
            ewid_c = CW'(gw_reg);
        end
        if (32'(gh_reg) > 32'(MAX_ROWS)) begin
            ehgt_c = RW'(MAX_ROWS);
        end else begin
            ehgt_c = RW'(gh_reg);
        end
        area_c = (AW + 1)'(ewid_c * ehgt_c);
    end

    // probe address
    assign rowmode = 32'(w_reg) < 32'(h_reg);
    assign n_len   = rowmode ? DW'(w_reg) : DW'(h_reg);
    assign l_len   = rowmode ? DW'(h_reg) : DW'(w_reg);

    always_comb begin
        case (state_reg)
            grm_pkg::ST_ANC_RD: begin
                ax = DW'(c_reg);
                ay = DW'(r_reg);
            end
            grm_pkg::ST_FC_RD, grm_pkg::ST_FM: begin
                if (rowmode) begin
                    ax = DW'(c_reg) + j_reg;
                    ay = DW'(r_reg) + i_reg;
                end else begin
                    ax = DW'(c_reg) + i_reg;
                    ay = DW'(r_reg) + j_reg;
                end
            end
            default: begin
                ax = DW'(pc_reg);
                ay = DW'(pr_reg);
            end
        endcase
        addr_full = PW'(ay) * PW'(ewid_reg) + PW'(ax);
        cell_addr = addr_full[AW-1:0];
    end

    assign open_c   = !lab_rdata[LW] && (walk_rdata == b_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == grm_pkg::ST_IDLE) && (!q_pend_reg || out_free);
    assign s_acc    = s_valid && s_ready;
    assign cell_ok  = 32'(s_cell_index) < 32'(CELLS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= grm_pkg::ST_IDLE;
            merged_reg  <= 1'b0;
            q_pend_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            merged_reg  <= merged_next;
            q_pend_reg  <= q_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ewid_reg    <= ewid_next;
        ehgt_reg    <= ehgt_next;
        area_reg    <= area_next;
        c_reg       <= c_next;
        r_reg       <= r_next;
        pc_reg      <= pc_next;
        pr_reg      <= pr_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        q_hit_reg   <= q_hit_next;
        m_kind_reg  <= m_kind_next;
        m_label_reg <= m_label_next;
    end

    always_comb begin
        state_next   = state_reg;
        ewid_next    = ewid_reg;
        ehgt_next    = ehgt_reg;
        area_next    = area_reg;
        merged_next  = merged_reg;
        c_next       = c_reg;
        r_next       = r_reg;
        pc_next      = pc_reg;
        pr_next      = pr_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        q_pend_next  = q_pend_reg;
        q_hit_next   = q_hit_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_label_next = m_label_reg;
        walk_we      = 1'b0;
        walk_waddr   = AW'(s_cell_index);
        walk_re      = 1'b0;
        walk_raddr   = cell_addr;
        lab_we       = 1'b0;
        lab_waddr    = cell_addr;
        lab_wdata    = {1'b1, LW'(k_reg)};
        lab_re       = 1'b0;
        lab_raddr    = cell_addr;
        adv          = 1'b0;
        runs_done    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pend_reg && out_free) begin
            q_pend_next  = 1'b0;
            m_valid_next = 1'b1;
            m_kind_next  = grm_pkg::KIND_LABEL;
            m_label_next = q_hit_reg ? lab_rdata[LW-1:0] : '0;
        end

        case (state_reg)
            grm_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (grm_pkg::op_t'(s_operation))
                        grm_pkg::OP_LOAD: begin
                            walk_we = cell_ok;
                        end
                        grm_pkg::OP_MERGE: begin
                            ewid_next   = ewid_c;
                            ehgt_next   = ehgt_c;
                            area_next   = area_c;
                            merged_next = 1'b1;
                            cnt_next    = '0;
                            c_next      = '0;
                            r_next      = '0;
                            if (area_c == '0) begin
                                state_next = grm_pkg::ST_DONE;
                            end else begin
                                state_next = grm_pkg::ST_CLEAR;
                            end
                        end
                        grm_pkg::OP_QUERY: begin
                            lab_re      = 1'b1;
                            lab_raddr   = AW'(s_cell_index);
                            q_pend_next = 1'b1;
                            q_hit_next  = merged_reg && (32'(s_cell_index) < 32'(area_reg));
                        end
                        default: begin
                        end
                    endcase
                end
            end
            grm_pkg::ST_CLEAR: begin
                lab_we    = 1'b1;
                lab_waddr = cnt_reg[AW-1:0];
                lab_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == area_reg) begin
                    state_next = grm_pkg::ST_ANC_RD;
                end
            end
            grm_pkg::ST_ANC_RD: begin
                walk_re    = 1'b1;
                lab_re     = 1'b1;
                k_next     = cell_addr;
                state_next = grm_pkg::ST_ANC_EV;
            end
            grm_pkg::ST_ANC_EV: begin
                if (lab_rdata[LW]) begin
                    adv = 1'b1;
                end else begin
                    b_next     = walk_rdata;
                    pc_next    = c_reg + 1'b1;
                    pr_next    = r_reg;
                    w_next     = '0;
                    state_next = grm_pkg::ST_RR_RD;
                end
            end
            grm_pkg::ST_RR_RD: begin
                if (pc_reg < ewid_reg) begin
                    walk_re    = 1'b1;
                    lab_re     = 1'b1;
                    state_next = grm_pkg::ST_RR_EV;
                end else begin
                    pc_next    = c_reg;
                    pr_next    = r_reg + 1'b1;
                    h_next     = '0;
                    state_next = grm_pkg::ST_RD_RD;
                end
            end
            grm_pkg::ST_RR_EV: begin
                if (open_c) begin
                    w_next     = w_reg + 1'b1;
                    pc_next    = pc_reg + 1'b1;
                    state_next = grm_pkg::ST_RR_RD;
                end else begin
                    pc_next    = c_reg;
                    pr_next    = r_reg + 1'b1;
                    h_next     = '0;
                    state_next = grm_pkg::ST_RD_RD;
                end
            end
            grm_pkg::ST_RD_RD: begin
                if (pr_reg < ehgt_reg) begin
                    walk_re    = 1'b1;
                    lab_re     = 1'b1;
                    state_next = grm_pkg::ST_RD_EV;
                end else begin
                    runs_done = 1'b1;
                end
            end
            grm_pkg::ST_RD_EV: begin
                if (open_c) begin
                    h_next     = h_reg + 1'b1;
                    pr_next    = pr_reg + 1'b1;
                    state_next = grm_pkg::ST_RD_RD;
                end else begin
                    runs_done = 1'b1;
                end
            end
            grm_pkg::ST_FC_RD: begin
                walk_re    = 1'b1;
                lab_re     = 1'b1;
                state_next = grm_pkg::ST_FC_EV;
            end
            grm_pkg::ST_FC_EV: begin
                if (!open_c) begin
                    adv = 1'b1;
                end else if (j_reg + 1'b1 == n_len) begin
                    j_next     = '0;
                    state_next = grm_pkg::ST_FM;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = grm_pkg::ST_FC_RD;
                end
            end
            grm_pkg::ST_FM: begin
                lab_we = 1'b1;
                if (j_reg + 1'b1 == n_len) begin
                    j_next = '0;
                    if (i_reg + 1'b1 == l_len) begin
                        adv = 1'b1;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = grm_pkg::ST_FC_RD;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            grm_pkg::ST_FIN_RD: begin
                lab_re     = 1'b1;
                lab_raddr  = cnt_reg[AW-1:0];
                state_next = grm_pkg::ST_FIN_EV;
            end
            grm_pkg::ST_FIN_EV: begin
                lab_we    = !lab_rdata[LW];
                lab_waddr = cnt_reg[AW-1:0];
                lab_wdata = {1'b1, LW'(cnt_reg)};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == area_reg) begin
                    state_next = grm_pkg::ST_DONE;
                end else begin
                    state_next = grm_pkg::ST_FIN_RD;
                end
            end
            grm_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = grm_pkg::KIND_MERGE;
                    m_label_next = '0;
                    state_next   = grm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = grm_pkg::ST_IDLE;
            end
        endcase

        if (runs_done) begin
            if (n_len == '0) begin
                adv = 1'b1;
            end else begin
                i_next     = '0;
                j_next     = '0;
                state_next = grm_pkg::ST_FC_RD;
            end
        end

        if (adv) begin
            state_next = grm_pkg::ST_ANC_RD;
            if (c_reg + 1'b1 == ewid_reg) begin
                c_next = '0;
                if (r_reg + 1'b1 == ehgt_reg) begin
                    cnt_next   = '0;
                    state_next = grm_pkg::ST_FIN_RD;
                end else begin
                    r_next = r_reg + 1'b1;
                end
            end else begin
                c_next = c_reg + 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply_kind  = m_kind_reg;
    assign m_block_label = m_label_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == grm_pkg::ST_IDLE)
        else $error("input ready outside idle");

    a_query_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pend_reg && !out_free |=> q_pend_reg && $stable(lab_rdata))
        else $error("pending query data lost");

    a_merge_label: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_kind == grm_pkg::KIND_MERGE |-> m_block_label == '0)
        else $error("merge beat with nonzero label");

    a_write_area: assert property (@(posedge aclk) disable iff (!aresetn)
        lab_we && state_reg != grm_pkg::ST_IDLE |-> 32'(lab_waddr) < 32'(area_reg))
        else $error("label write outside grid");
`endif

endmodule
